>>> rtl/core/cordic_cartesian_to_polar_core_defines.svh
// assertion macros for the cartesian to polar core
`ifndef CORDIC_CARTESIAN_TO_POLAR_CORE_DEFINES_SVH
`define CORDIC_CARTESIAN_TO_POLAR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define CCP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ccp assertion failed");

`define CCP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ccp assertion failed");

`else

`define CCP_ASSERT(lbl, clk, rst, prop)

`define CCP_ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

>>> rtl/core/ccp_pkg.sv
package ccp_pkg;

   localparam int TABLE_LEN = 24;
   localparam int DEG_W     = 36;
   localparam int ASUM_W    = 64;
   localparam int SPLIT     = 17;

   localparam logic signed [DEG_W-1:0] DEG_180 = DEG_W'(64'sd180 * 64'sd16777216);

   localparam logic [29:0] GAIN_Q30 =
      30'((64'd607252935 * 64'd1073741824 + 64'd500000000) / 64'd1000000000);
   localparam logic [24:0] RAD_Q30 =
      25'((64'd174533 * 64'd1073741824 + 64'd5000000) / 64'd10000000);

   localparam logic [30:0] MAG_MAX   = 31'h7fffffff;
   localparam longint      ANGLE_MAX = 64'sd52707179;

   typedef enum logic [1:0] {
      QUAD_NONE,
      QUAD_LOWER,
      QUAD_UPPER
   } quad_type;

   // arctangent of 2^-idx in degrees, scaled by 1e10
   function automatic longint atan_scaled(input int idx);
      longint v;
      begin
         case (idx)
            0:  v = 64'sd450000000000;
            1:  v = 64'sd265650511800;
            2:  v = 64'sd140362434700;
            3:  v = 64'sd71250163490;
            4:  v = 64'sd35763343750;
            5:  v = 64'sd17899106080;
            6:  v = 64'sd8951737102;
            7:  v = 64'sd4476141709;
            8:  v = 64'sd2238105004;
            9:  v = 64'sd1119056771;
            10: v = 64'sd559528919;
            11: v = 64'sd279764526;
            12: v = 64'sd139882271;
            13: v = 64'sd69941137;
            14: v = 64'sd34970569;
            15: v = 64'sd17485284;
            16: v = 64'sd8742642;
            17: v = 64'sd4371321;
            18: v = 64'sd2185661;
            19: v = 64'sd1092830;
            20: v = 64'sd546415;
            21: v = 64'sd273208;
            22: v = 64'sd136604;
            23: v = 64'sd68302;
            default: v = 64'sd0;
         endcase
         return v;
      end
   endfunction

   // degrees in units of 2^-24, rounded to nearest
   function automatic logic signed [DEG_W-1:0] atan_deg(input int idx);
      longint s;
      begin
         s = atan_scaled(idx);
         return DEG_W'((s * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000);
      end
   endfunction

endpackage

>>> rtl/core/cordic_cartesian_to_polar_core.sv
// stages in order: input fold, micro-rotations, quadrant fold and clamp, partial products, recombine and round
// throughput: one item per cycle while rsp_tready does not stall, one unrolled micro-rotation per pipeline stage
// each stage holds its item until the next stage can take it, so stalls drop nothing
// reset: synchronous, active high, clears all stage valid bits
`include "cordic_cartesian_to_polar_core_defines.svh"

module cordic_cartesian_to_polar_core
   import ccp_pkg::*;
#(
   parameter int ITERATIONS = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_in [31:0], y_in [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // magnitude [30:0], angle_rad [57:31], zeros above
);

   localparam int CW   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int XW   = CW + 4;
   localparam int NSTG = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int S    = NSTG + 4;
   localparam int HIW  = XW - 1 - SPLIT;
   localparam int MSUM_W = XW + 30;
   localparam int DHW  = DEG_W - SPLIT;

   logic [0:S]  en;
   logic [0:S-1] v_ff;

   logic signed [XW-1:0]    x_ff [0:NSTG];
   logic signed [XW-1:0]    y_ff [0:NSTG];
   logic signed [DEG_W-1:0] d_ff [0:NSTG];
   quad_type                q_ff [0:NSTG];

   // stall chain: a stage loads when it is empty or its contents move on
   assign en[S] = rsp_tready;
   genvar g;
   generate
      for (g = 0; g < S; g++) begin : g_en
         assign en[g] = !v_ff[g] || en[g+1];
      end
   endgenerate

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // input stage: sign extend and fold into the right half plane
   logic signed [XW-1:0] cx, cy;
   logic signed [XW-1:0] x0_in;
   quad_type             q0_in;

   assign cx = XW'($signed(req_tdata[CW-1:0]));
   assign cy = XW'($signed(req_tdata[32+CW-1:32]));

   always_comb begin
      if (cx[XW-1]) begin
         x0_in = -cx;
         q0_in = cy[XW-1] ? QUAD_LOWER : QUAD_UPPER;
      end else begin
         x0_in = cx;
         q0_in = QUAD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= cy;
         d_ff[0] <= '0;
         q_ff[0] <= q0_in;
      end
   end

   // one vectoring micro-rotation per stage
   generate
      for (g = 0; g < NSTG; g++) begin : g_rot
         localparam logic signed [XW-1:0] RND =
            (g == 0) ? XW'(0) : XW'(64'sd1 <<< (g - 1));
         localparam logic signed [DEG_W-1:0] ATAN = atan_deg(g);
         logic signed [XW-1:0]    sx, sy, dx, dy;
         logic signed [XW-1:0]    xs_in, ys_in;
         logic signed [DEG_W-1:0] ds_in;

         always_comb begin
            if (y_ff[g][XW-1]) begin
               sx    = x_ff[g];
               sy    = y_ff[g];
               ds_in = d_ff[g] - ATAN;
            end else begin
               sx    = -x_ff[g];
               sy    = -y_ff[g];
               ds_in = d_ff[g] + ATAN;
            end
            dx    = (sy + RND) >>> g;
            dy    = (sx + RND) >>> g;
            xs_in = x_ff[g] - dx;
            ys_in = y_ff[g] + dy;
         end

         always_ff @(posedge clock) begin
            if (en[g+1]) begin
               x_ff[g+1] <= xs_in;
               y_ff[g+1] <= ys_in;
               d_ff[g+1] <= ds_in;
               q_ff[g+1] <= q_ff[g];
            end
         end
      end
   endgenerate

   // quadrant fold and radius clamp
   logic [XW-2:0]           xc_ff, xc_in;
   logic signed [DEG_W-1:0] df_ff, df_in;

   always_comb begin
      xc_in = x_ff[NSTG][XW-1] ? '0 : x_ff[NSTG][XW-2:0];
      case (q_ff[NSTG])
         QUAD_LOWER: df_in = -DEG_180 - d_ff[NSTG];
         QUAD_UPPER: df_in = DEG_180 - d_ff[NSTG];
         default:    df_in = d_ff[NSTG];
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[NSTG+1]) begin
         xc_ff <= xc_in;
         df_ff <= df_in;
      end
   end

   // partial products of the gain and degree-to-radian scaling
   logic [SPLIT+29:0]        pm_lo_ff, pm_lo_in;
   logic [HIW+29:0]          pm_hi_ff, pm_hi_in;
   logic [SPLIT+24:0]        pa_lo_ff, pa_lo_in;
   logic signed [DHW+25:0]   pa_hi_ff, pa_hi_in;
   logic signed [DHW-1:0]    dhi;
   logic signed [25:0]       rad_s;

   assign dhi   = df_ff[DEG_W-1:SPLIT];
   assign rad_s = $signed({1'b0, RAD_Q30});

   always_comb begin
      pm_lo_in = (SPLIT+30)'(xc_ff[SPLIT-1:0]) * (SPLIT+30)'(GAIN_Q30);
      pm_hi_in = (HIW+30)'(xc_ff[XW-2:SPLIT]) * (HIW+30)'(GAIN_Q30);
      pa_lo_in = (SPLIT+25)'(df_ff[SPLIT-1:0]) * (SPLIT+25)'(RAD_Q30);
      pa_hi_in = (DHW+26)'(dhi) * (DHW+26)'(rad_s);
   end

   always_ff @(posedge clock) begin
      if (en[NSTG+2]) begin
         pm_lo_ff <= pm_lo_in;
         pm_hi_ff <= pm_hi_in;
         pa_lo_ff <= pa_lo_in;
         pa_hi_ff <= pa_hi_in;
      end
   end

   // recombine, round and saturate
   logic [MSUM_W-1:0]        msum;
   logic [XW-1:0]            mq;
   logic signed [ASUM_W-1:0] asum, aq;
   logic [30:0]              mag_ff, mag_in;
   logic signed [26:0]       ang_ff, ang_in;

   always_comb begin
      msum = (MSUM_W'(pm_hi_ff) << SPLIT) + MSUM_W'(pm_lo_ff)
           + (MSUM_W'(1) << 29);
      mq   = msum[MSUM_W-1:30];
      if (64'(mq) > 64'(MAG_MAX)) begin
         mag_in = MAG_MAX;
      end else begin
         mag_in = 31'(mq);
      end

      asum = (ASUM_W'(pa_hi_ff) <<< SPLIT) + $signed(ASUM_W'(pa_lo_ff))
           + (ASUM_W'(1) <<< 29);
      aq   = asum >>> 30;
      if (aq > ANGLE_MAX) begin
         ang_in = 27'(ANGLE_MAX);
      end else if (aq < -ANGLE_MAX) begin
         ang_in = 27'(-ANGLE_MAX);
      end else begin
         ang_in = 27'(aq);
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG+3]) begin
         mag_ff <= mag_in;
         ang_ff <= ang_in;
      end
   end

   assign rsp_tdata = {6'b0, ang_ff, mag_ff};

   `CCP_ASSERT(a_ang_range, clock, reset,
      rsp_tvalid |-> (ang_ff <= ANGLE_MAX && ang_ff >= -ANGLE_MAX))
   `CCP_ASSERT(a_ready_when_empty, clock, reset, !v_ff[0] |-> req_tready)
   `CCP_ASSERT_NEXT(a_move_to_out, clock, reset, en[S-1] && v_ff[S-2], rsp_tvalid)
   `CCP_ASSERT_NEXT(a_accept_lands, clock, reset, req_tvalid && req_tready, v_ff[0])

endmodule

>>> verif/cordic_cartesian_to_polar_core_tb.sv
`timescale 1ns / 100ps

class polar_scoreboard;
   typedef struct {
      logic [30:0] mag;
      logic [26:0] ang;
   } polar_type;

   localparam int ITERS = 16;

   polar_type expected_polar[$];
   longint atan_units[ITERS];
   longint gain_q30;
   longint rad_q30;
   int fails;
   int shown;

   function new();
      longint atan_e10[ITERS];
      atan_e10 = '{64'sd450000000000, 64'sd265650511800, 64'sd140362434700,
                   64'sd71250163490, 64'sd35763343750, 64'sd17899106080,
                   64'sd8951737102, 64'sd4476141709, 64'sd2238105004,
                   64'sd1119056771, 64'sd559528919, 64'sd279764526,
                   64'sd139882271, 64'sd69941137, 64'sd34970569, 64'sd17485284};
      foreach (atan_units[i])
         atan_units[i] = (atan_e10[i] * 64'sd16777216 + 64'sd5000000000) / 64'sd10000000000;
      gain_q30 = (64'sd607252935 * 64'sd1073741824 + 64'sd500000000) / 64'sd1000000000;
      rad_q30  = (64'sd174533 * 64'sd1073741824 + 64'sd5000000) / 64'sd10000000;
      fails = 0;
      shown = 0;
   endfunction

   // round to nearest, ties toward plus infinity
   function longint round_down_by(longint v, int s);
      if (s == 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function int pending();
      return expected_polar.size();
   endfunction

   function void note_point(logic [31:0] x_raw, logic [31:0] y_raw);
      longint x, y, deg, sigma, dx, dy, m, a;
      ccp_pkg::quad_type q;
      polar_type p;
      x = longint'($signed(x_raw));
      y = longint'($signed(y_raw));
      deg = 0;
      q = ccp_pkg::QUAD_NONE;
      if (x < 0) begin
         x = -x;
         q = (y < 0) ? ccp_pkg::QUAD_LOWER : ccp_pkg::QUAD_UPPER;
      end
      for (int i = 0; i < ITERS; i++) begin
         sigma = (y < 0) ? 64'sd1 : -64'sd1;
         dx = round_down_by(sigma * y, i);
         dy = round_down_by(sigma * x, i);
         x = x - dx;
         y = y + dy;
         deg = deg - sigma * atan_units[i];
      end
      if (q == ccp_pkg::QUAD_LOWER) deg = -64'sd180 * 64'sd16777216 - deg;
      else if (q == ccp_pkg::QUAD_UPPER) deg = 64'sd180 * 64'sd16777216 - deg;
      if (x < 0) x = 0;
      m = round_down_by(x * gain_q30, 30);
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      a = round_down_by(deg * rad_q30, 30);
      if (a > 64'sd52707179) a = 64'sd52707179;
      if (a < -64'sd52707179) a = -64'sd52707179;
      p.mag = m[30:0];
      p.ang = a[26:0];
      expected_polar.push_back(p);
   endfunction

   function void check_result(logic [63:0] tdata);
      polar_type p;
      if (expected_polar.size() == 0) begin
         fails++;
         if (shown < 10) begin
            shown++;
            $display("unexpected item: tdata %h", tdata);
         end
         return;
      end
      p = expected_polar.pop_front();
      if (tdata[30:0] !== p.mag || tdata[57:31] !== p.ang || tdata[63:58] !== 6'd0) begin
         fails++;
         if (shown < 10) begin
            shown++;
            $display("mismatch: mag exp %h got %h, angle exp %h got %h, pad got %h",
                     p.mag, tdata[30:0], p.ang, tdata[57:31], tdata[63:58]);
         end
      end
   endfunction
endclass

module cordic_cartesian_to_polar_core_tb;
   localparam int     LATENCY = 20;
   localparam longint LIMIT   = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [63:0] rsp_tdata;

   int     send_idle_pct  = 0;
   int     recv_stall_pct = 0;
   int     hold_len       = 0;
   longint cycles         = 0;

   polar_scoreboard sb = new();

   // {y, x}
   logic [63:0] directed_points [24] = '{
      {32'h00000000, 32'h00000000}, {32'h7fffffff, 32'h7fffffff},
      {32'h80000000, 32'h80000000}, {32'h00000000, 32'h80000000},
      {32'h80000000, 32'h00000000}, {32'h00000000, 32'h7fffffff},
      {32'h7fffffff, 32'h00000000}, {32'h00000000, 32'hffffffff},
      {32'hffffffff, 32'h80000000}, {32'h7fffffff, 32'h80000000},
      {32'h80000000, 32'h7fffffff}, {32'h00000000, 32'h01000000},
      {32'h00000000, 32'hff000000}, {32'hff000000, 32'h00000000},
      {32'h01000000, 32'h01000000}, {32'hff000000, 32'hff000000},
      {32'h01000000, 32'hff000000}, {32'hff000000, 32'h01000000},
      {32'h00000001, 32'h00000001}, {32'hffffffff, 32'hffffffff},
      {32'h00000001, 32'hfffffffe}, {32'h80000000, 32'h00000001},
      {32'haaaaaaaa, 32'h55555555}, {32'h55555555, 32'haaaaaaaa}
   };

   cordic_cartesian_to_polar_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   task automatic send_point(input logic [31:0] x, input logic [31:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_point(x, y);
   endtask

   function automatic logic [63:0] random_point();
      logic [31:0] x, y;
      int k;
      k = $urandom_range(9);
      x = $urandom;
      y = $urandom;
      case (k)
         5, 6: begin
            x = $signed(x) >>> $urandom_range(31);
            y = $signed(y) >>> $urandom_range(31);
         end
         7: begin
            if ($urandom_range(1)) x = '0;
            else y = '0;
         end
         // near the negative x axis, where the angle folds to plus or minus pi
         8: begin
            x = x | 32'h80000000;
            y = $urandom_range(2) - 1;
         end
         9: y = $urandom_range(1) ? x : -x;
         default: ;
      endcase
      return {y, x};
   endfunction

   task automatic run_phase(input int n, input int idle, input int stall);
      logic [63:0] p;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (n) begin
         p = random_point();
         send_point(p[31:0], p[63:32]);
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (hold_len > 0) begin
            rsp_tready <= 1'b0;
            hold_len = hold_len - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_points[i])
         send_point(directed_points[i][31:0], directed_points[i][63:32]);

      run_phase(130, 0, 0);
      run_phase(130, 49, 0);
      run_phase(130, 0, 49);
      run_phase(130, 34, 34);
      // long receiver hold-off while the sender keeps offering
      hold_len = 300;
      run_phase(130, 0, 0);

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
